// File: hw/rtl/clcs_pkg.sv
// ----------------------------------------------------------------------------
// clcs_pkg: shared types and constants for the line center steering unit
// Geometry of the frame, register indexes and the front/back handoff word.
// ----------------------------------------------------------------------------
`default_nettype none
package clcs_pkg;
  localparam int ROW_PIXELS = 320;
  localparam int FRAME_ROWS = 240;
  localparam int RUN_ROWS   = 4;
  localparam int ROW_BYTES  = (ROW_PIXELS + 7) / 8;
  localparam int COL_W      = 6;
  localparam int ROWC_W     = 8;
  localparam int CW         = 10;
  localparam int QDEPTH     = 2;

  localparam logic [2:0] CFG_P_GAIN  = 3'd0;
  localparam logic [2:0] CFG_D_GAIN  = 3'd1;
  localparam logic [2:0] CFG_CREF    = 3'd2;
  localparam logic [2:0] CFG_NEUTRAL = 3'd3;
  localparam logic [2:0] CFG_SMIN    = 3'd4;
  localparam logic [2:0] CFG_SMAX    = 3'd5;
  localparam logic [2:0] CFG_WHITE   = 3'd6;

  // Per-frame outcome passed from the pixel front end to the PD back end.
  typedef struct packed {
    logic          locked;
    logic [CW-1:0] center;
  } frame_res_t;
endpackage
`default_nettype wire

// File: hw/rtl/camera_line_center_steering_unit.sv
// ----------------------------------------------------------------------------
// camera_line_center_steering_unit: line follower steering from camera bytes
// Finds the line center per row, picks a frame target and runs a PD step.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake             Payload
// in_       in   in_valid/in_ready     in_pixel_byte, in_frame_start
// out_      out  out_valid/out_ready   servo, target, error, line_found
// cfg_      in   cfg_we                cfg_index, cfg_data
//
// One pixel byte is taken every cycle while in_ready is high; all eight
// pixels are scanned at once. A frame's result passes the queue and back end
// stages and is held in the output register until taken. Results wait in a
// two-entry queue, so in_ready drops only when that queue is full. Reset is
// synchronous and restores the register defaults; there is no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none
module camera_line_center_steering_unit import clcs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_pixel_byte,
  input  wire logic        in_frame_start,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_servo_pulse,
  output logic [9:0]       out_target_center,
  output logic signed [10:0] out_steering_error,
  output logic             out_line_found,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  logic [15:0] p_gain_r, d_gain_r;
  logic [9:0]  cref_r;
  logic [11:0] neutral_r, smin_r, smax_r;
  logic        white_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_gain_r <= '0; d_gain_r <= '0; cref_r <= 10'd160; neutral_r <= 12'd1200;
      smin_r <= 12'd800; smax_r <= 12'd2000; white_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_P_GAIN:  p_gain_r  <= cfg_data;
        CFG_D_GAIN:  d_gain_r  <= cfg_data;
        CFG_CREF:    cref_r    <= cfg_data[9:0];
        CFG_NEUTRAL: neutral_r <= cfg_data[11:0];
        CFG_SMIN:    smin_r    <= cfg_data[11:0];
        CFG_SMAX:    smax_r    <= cfg_data[11:0];
        CFG_WHITE:   white_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic       take, fr_valid, q_full, q_empty, q_rd;
  frame_res_t fr, q_data;
  logic [10:0] err;

  assign in_ready = !q_full;
  assign take = in_valid && in_ready;

  clcs_front u_front (
    .clk, .rst_n, .white_level(white_r), .take,
    .pixel_byte(in_pixel_byte), .frame_start(in_frame_start),
    .res_valid(fr_valid), .res(fr)
  );

  clcs_queue u_queue (
    .clk, .rst_n, .wr_en(fr_valid), .wr_data(fr), .full(q_full),
    .empty(q_empty), .rd_en(q_rd), .rd_data(q_data)
  );

  clcs_back u_back (
    .clk, .rst_n, .p_gain(p_gain_r), .d_gain(d_gain_r), .center_reference(cref_r),
    .servo_neutral(neutral_r), .servo_min(smin_r), .servo_max(smax_r),
    .q_empty, .q_data, .q_rd, .out_valid, .out_ready, .out_servo_pulse,
    .out_target_center, .out_steering_error(err), .out_line_found
  );
  assign out_steering_error = err;

  // A finished frame never lands in a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    fr_valid |-> !q_full) else $error("frame result written into full queue");
  // The back end never pulls from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_rd |-> !q_empty) else $error("queue read while empty");
  // A result that is not taken stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_servo_pulse))
    else $error("output result changed while stalled");
endmodule
`default_nettype wire

// File: hw/rtl/clcs_front.sv
// ----------------------------------------------------------------------------
// clcs_front: edge detection and run tracking
// Scans eight pixels per byte and emits the frame's chosen center at frame end.
// ----------------------------------------------------------------------------
`default_nettype none
module clcs_front import clcs_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       white_level,
  input  wire logic       take,
  input  wire logic [7:0] pixel_byte,
  input  wire logic       frame_start,
  output logic            res_valid,
  output frame_res_t      res
);
  typedef enum logic [2:0] {
    PH_RISE = 3'b001,
    PH_FALL = 3'b010,
    PH_DONE = 3'b100
  } edge_phase_t;

  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROWC_W-1:0] row_r, row_nxt;
  edge_phase_t       ph_r, ph_nxt;
  logic [2:0]        hist_r, hist_nxt;
  logic [CW-1:0]     rise_r, rise_nxt, fall_r, fall_nxt;
  logic [2:0]        run_r, run_nxt;
  logic [CW-1:0]     start_r, start_nxt, chosen_r, chosen_nxt;
  logic              lock_r, lock_nxt;

  always_comb begin
    logic [CW:0]  p, ctr_w;
    logic [CW-1:0] ctr;
    logic         w, h0, h1, h2;
    col_nxt = col_r; row_nxt = row_r; ph_nxt = ph_r; hist_nxt = hist_r;
    rise_nxt = rise_r; fall_nxt = fall_r; run_nxt = run_r;
    start_nxt = start_r; chosen_nxt = chosen_r; lock_nxt = lock_r;
    res_valid = 1'b0;
    res = '0;
    p = '0; ctr_w = '0; ctr = '0; w = 1'b0; h0 = 1'b0; h1 = 1'b0; h2 = 1'b0;
    if (take) begin
      if (frame_start) begin
        col_nxt = '0; row_nxt = '0; ph_nxt = PH_RISE; hist_nxt = '0;
        rise_nxt = '0; fall_nxt = '0; run_nxt = '0; start_nxt = '0;
        chosen_nxt = '0; lock_nxt = 1'b0;
      end
      for (int k = 0; k < 8; k++) begin
        p = (CW+1)'(col_nxt) * (CW+1)'(8) + (CW+1)'(k);
        if (p < (CW+1)'(ROW_PIXELS)) begin
          w  = (pixel_byte[7-k] == white_level);
          h0 = hist_nxt[0]; h1 = hist_nxt[1]; h2 = hist_nxt[2];
          if (ph_nxt == PH_RISE) begin
            if (p == (CW+1)'(2)) begin
              if (h1 && h0 && w) begin
                rise_nxt = '0; ph_nxt = PH_FALL;
              end
            end else if (p >= (CW+1)'(3)) begin
              if (!h2 && !h1 && h0 && w) begin
                rise_nxt = CW'(p - 1'b1); ph_nxt = PH_FALL;
              end
            end
          end else if (ph_nxt == PH_FALL) begin
            if (p >= {1'b0, rise_nxt} + (CW+1)'(3) && h2 && h1 && !h0 && !w) begin
              fall_nxt = CW'(p - 1'b1); ph_nxt = PH_DONE;
            end
          end
          hist_nxt = {hist_nxt[1:0], w};
        end
      end
      col_nxt = col_nxt + 1'b1;
      if (col_nxt >= COL_W'(ROW_BYTES)) begin
        if (ph_nxt == PH_FALL) ctr_w = {1'b0, rise_nxt} + (CW+1)'(ROW_PIXELS);
        else                   ctr_w = {1'b0, rise_nxt} + {1'b0, fall_nxt};
        ctr = (ph_nxt == PH_RISE) ? '0 : ctr_w[CW:1];
        if (ctr != '0) begin
          if (run_nxt == '0) start_nxt = ctr;
          if (run_nxt < 3'd7) run_nxt = run_nxt + 1'b1;
          if (!lock_nxt && run_nxt >= 3'(RUN_ROWS)) begin
            chosen_nxt = start_nxt; lock_nxt = 1'b1;
          end
        end else begin
          run_nxt = '0;
        end
        col_nxt = '0; ph_nxt = PH_RISE; hist_nxt = '0; rise_nxt = '0; fall_nxt = '0;
        row_nxt = row_nxt + 1'b1;
        if (row_nxt >= ROWC_W'(FRAME_ROWS)) begin
          res_valid  = 1'b1;
          res.locked = lock_nxt;
          res.center = chosen_nxt;
          row_nxt = '0; run_nxt = '0; start_nxt = '0; chosen_nxt = '0; lock_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0; ph_r <= PH_RISE; hist_r <= '0; rise_r <= '0;
      fall_r <= '0; run_r <= '0; start_r <= '0; chosen_r <= '0; lock_r <= 1'b0;
    end else begin
      col_r <= col_nxt; row_r <= row_nxt; ph_r <= ph_nxt; hist_r <= hist_nxt;
      rise_r <= rise_nxt; fall_r <= fall_nxt; run_r <= run_nxt;
      start_r <= start_nxt; chosen_r <= chosen_nxt; lock_r <= lock_nxt;
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/clcs_queue.sv
// ----------------------------------------------------------------------------
// clcs_queue: two-entry queue between front and back end
// Holds frame outcomes so the back end may stall without stopping pixels.
// ----------------------------------------------------------------------------
`default_nettype none
module clcs_queue import clcs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_en,
  input  frame_res_t wr_data,
  output logic       full,
  output logic       empty,
  input  wire logic  rd_en,
  output frame_res_t rd_data
);
  frame_res_t mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full    = (cnt_r == 2'(QDEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= ~wp_r;
      if (rd_en) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end
endmodule
`default_nettype wire

// File: hw/rtl/clcs_back.sv
// ----------------------------------------------------------------------------
// clcs_back: PD step and servo clamp
// Three stages: error and products, sum and scale, clamp into output register.
// ----------------------------------------------------------------------------
`default_nettype none
module clcs_back import clcs_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic [15:0] p_gain,
  input  wire logic [15:0] d_gain,
  input  wire logic [9:0]  center_reference,
  input  wire logic [11:0] servo_neutral,
  input  wire logic [11:0] servo_min,
  input  wire logic [11:0] servo_max,
  input  wire logic        q_empty,
  input  frame_res_t       q_data,
  output logic             q_rd,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      out_servo_pulse,
  output logic [9:0]       out_target_center,
  output logic [10:0]      out_steering_error,
  output logic             out_line_found
);
  // The D term needs the previous error, so one frame is in flight at a time;
  // frames are thousands of bytes apart, so this never limits the rate.
  logic               s1_r, s2_r, busy;
  logic signed [10:0] perr_r;
  logic signed [27:0] ep_r, ed_r;
  logic signed [36:0] u_r;
  logic [9:0]         tgt_r, tgt_nxt;
  logic signed [11:0] e_r, e_nxt, de;
  logic               lk_r;
  logic signed [27:0] dterm;
  logic signed [36:0] sum, u, v;
  logic [11:0]        pulse;

  assign busy = s1_r || s2_r || out_valid;
  assign q_rd = !q_empty && !busy;
  assign tgt_nxt = q_data.locked ? q_data.center : center_reference;
  assign e_nxt = $signed({2'b00, center_reference}) - $signed({2'b00, tgt_nxt});
  assign de = e_nxt - 12'(perr_r);
  assign dterm = (ed_r < 0) ? -((-ed_r) >>> 8) : (ed_r >>> 8);
  assign sum = 37'(ep_r) + 37'(dterm) * 37'sd256;
  assign u = (sum < 0) ? -((-sum) >>> 8) : (sum >>> 8);
  assign v = $signed({25'd0, servo_neutral}) - u_r;

  always_comb begin
    if (v <= $signed({25'd0, servo_min}))      pulse = servo_min;
    else if (v >= $signed({25'd0, servo_max})) pulse = servo_max;
    else                                       pulse = v[11:0];
  end

  always_ff @(posedge clk) begin
    if (q_rd) begin
      ep_r  <= 28'(e_nxt) * 28'($signed(p_gain));
      ed_r  <= 28'(de) * 28'($signed(d_gain));
      tgt_r <= tgt_nxt;
      e_r   <= e_nxt;
      lk_r  <= q_data.locked;
    end
    if (s1_r) u_r <= u;
    if (s2_r) begin
      out_servo_pulse    <= pulse;
      out_target_center  <= tgt_r;
      out_steering_error <= e_r[10:0];
      out_line_found     <= lk_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= 1'b0; s2_r <= 1'b0; out_valid <= 1'b0; perr_r <= '0;
    end else begin
      s1_r <= q_rd;
      s2_r <= s1_r;
      if (q_rd) perr_r <= e_nxt[10:0];
      if (s2_r) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire
